@@ rtl/core/per_channel_circuit_breaker_top_assert.svh @@
// Assertion macros used by the breaker engine RTL (pcb_back)
`ifndef PER_CHANNEL_CIRCUIT_BREAKER_TOP_ASSERT_SVH
`define PER_CHANNEL_CIRCUIT_BREAKER_TOP_ASSERT_SVH

// same-cycle implication
`define PCB_AST_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcb assertion failed");

// next-cycle implication
`define PCB_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pcb assertion failed");

`endif

@@ rtl/core/pcb_pkg.sv @@
// ----------------------------------------------------------------------------
// pcb_pkg
// Types, codes and helpers of the per-channel circuit breaker table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcb_pkg;

    localparam int CHANNELS = 64;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam logic [2:0] REQ_ADMIT = 3'd0;
    localparam logic [2:0] REQ_SUCC  = 3'd1;
    localparam logic [2:0] REQ_FAIL  = 3'd2;
    localparam logic [2:0] REQ_RESET = 3'd3;
    localparam logic [2:0] REQ_QUERY = 3'd4;
    localparam logic [2:0] REQ_TICK  = 3'd5;
    localparam logic [2:0] REQ_SWEEP = 3'd6;

    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    localparam logic [1:0] REG_THR  = 2'd0;
    localparam logic [1:0] REG_TMO  = 2'd1;
    localparam logic [1:0] REG_MAXP = 2'd2;
    localparam logic [1:0] REG_MAXC = 2'd3;

    typedef struct packed {
        logic [2:0] req;
        logic [5:0] ch;
    } t_item;

    typedef struct packed {
        logic [15:0] thr;
        logic [30:0] tmo;
        logic [7:0]  maxp;
        logic [6:0]  maxc;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] fail_run;
        logic [7:0]  probes;
        logic [31:0] open_time;
        logic [31:0] fail_total;
        logic [31:0] succ_total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        allowed;
        logic [1:0]  state;
        logic        found;
        logic [15:0] fail_run;
        logic [7:0]  probes;
        logic [31:0] fail_total;
        logic [31:0] succ_total;
        logic [31:0] opened;
    } t_res;

    function automatic logic [31:0] sat32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

@@ rtl/core/pcb_ram.sv @@
// ----------------------------------------------------------------------------
// pcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pcb_front.sv @@
// ----------------------------------------------------------------------------
// pcb_front
// Request intake: a two-word queue between the command port and the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pcb_pkg::t_item i_item,
    output logic          o_busy,
    output logic          o_vld,
    output pcb_pkg::t_item o_item,
    input  logic          i_pop
);

    pcb_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;

    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy;
    assign o_vld  = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

@@ rtl/core/pcb_back.sv @@
// ----------------------------------------------------------------------------
// pcb_back
// Breaker engine: read-modify-write of one table entry per word, sweep walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_channel_circuit_breaker_top_assert.svh"

module pcb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  pcb_pkg::t_item i_item,
    output logic           o_pop,
    input  pcb_pkg::t_cfg  i_cfg,
    output logic           o_res_vld,
    output pcb_pkg::t_res  o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SWP  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EX   = 2'd3;

    localparam logic [pcb_pkg::CH_W-1:0] LAST_IDX = pcb_pkg::CH_W'(pcb_pkg::CHANNELS - 1);

    logic [1:0]                    r_state, n_state;
    pcb_pkg::t_item                r_item, n_item;
    logic [pcb_pkg::CH_W-1:0]      r_idx, n_idx;
    logic [pcb_pkg::CHANNELS-1:0]  r_valid, n_valid;
    logic [6:0]                    r_tracked, n_tracked;
    logic [31:0]                   r_now, n_now;
    logic [31:0]                   r_opened, n_opened;
    logic                          r_res_vld, n_res_vld;
    pcb_pkg::t_res                 r_res, n_res;

    logic                          we;
    logic [pcb_pkg::CH_W-1:0]      waddr;
    logic [pcb_pkg::CH_W-1:0]      raddr;
    pcb_pkg::t_entry               wdata;
    pcb_pkg::t_entry               rdata;
    pcb_pkg::t_entry               e;
    pcb_pkg::t_entry               ne;
    logic [pcb_pkg::CH_W-1:0]      ch;
    logic                          vld;
    logic                          create;
    logic                          found;
    logic                          allowed;
    logic [15:0]                   fr;

    pcb_ram #(
        .WIDTH (pcb_pkg::ENTRY_W),
        .DEPTH (pcb_pkg::CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    function automatic logic timed(input logic [31:0] now, input logic [31:0] t0,
                                   input logic [30:0] tmo);
        logic [31:0] el;
        el = now - t0;
        return el >= {1'b0, tmo};
    endfunction

    assign ch = r_item.ch[pcb_pkg::CH_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_tracked = r_tracked;
        n_now     = r_now;
        n_opened  = r_opened;
        n_res_vld = 1'b0;
        n_res     = r_res;
        o_pop     = 1'b0;
        we        = 1'b0;
        waddr     = ch;
        raddr     = ch;
        wdata     = rdata;
        vld       = r_valid[ch];
        create    = 1'b0;
        found     = 1'b0;
        allowed   = 1'b0;
        e         = '0;
        ne        = '0;
        fr        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_vld) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    if (i_item.req == pcb_pkg::REQ_SWEEP) begin
                        raddr   = '0;
                        n_idx   = '0;
                        n_state = S_SWP;
                    end else begin
                        raddr   = i_item.ch[pcb_pkg::CH_W-1:0];
                        n_state = S_EX;
                    end
                end
            end
            S_SWP: begin
                waddr = r_idx;
                wdata = rdata;
                wdata.mode   = pcb_pkg::MODE_HALF;
                wdata.probes = '0;
                we = r_valid[r_idx] && (rdata.mode == pcb_pkg::MODE_OPEN)
                     && timed(r_now, rdata.open_time, i_cfg.tmo);
                if (r_idx == LAST_IDX) begin
                    n_state = S_RD;
                end else begin
                    raddr = r_idx + 1'b1;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                create = ((r_item.req == pcb_pkg::REQ_SUCC) || (r_item.req == pcb_pkg::REQ_FAIL))
                         && !vld && (r_tracked < i_cfg.maxc);
                found  = vld || create;
                e      = vld ? rdata : '0;
                ne     = e;
                case (r_item.req)
                    pcb_pkg::REQ_ADMIT: begin
                        if (!found || e.mode == pcb_pkg::MODE_CLOSED) begin
                            allowed = 1'b1;
                        end else if (e.mode == pcb_pkg::MODE_OPEN) begin
                            if (timed(r_now, e.open_time, i_cfg.tmo)) begin
                                ne.mode   = pcb_pkg::MODE_HALF;
                                ne.probes = 8'd1;
                                allowed   = 1'b1;
                            end
                        end else if (e.probes < i_cfg.maxp) begin
                            ne.probes = e.probes + 8'd1;
                            allowed   = 1'b1;
                        end
                    end
                    pcb_pkg::REQ_SUCC: begin
                        ne.fail_run   = '0;
                        ne.succ_total = pcb_pkg::sat32(e.succ_total);
                        if (e.mode == pcb_pkg::MODE_HALF) begin
                            ne.mode = pcb_pkg::MODE_CLOSED;
                        end
                    end
                    pcb_pkg::REQ_FAIL: begin
                        ne.fail_total = pcb_pkg::sat32(e.fail_total);
                        fr = pcb_pkg::sat16(e.fail_run);
                        if (e.mode == pcb_pkg::MODE_CLOSED) begin
                            ne.fail_run = fr;
                            if (fr >= i_cfg.thr) begin
                                ne.mode      = pcb_pkg::MODE_OPEN;
                                ne.open_time = r_now;
                                if (found) begin
                                    n_opened = pcb_pkg::sat32(r_opened);
                                end
                            end
                        end else if (e.mode == pcb_pkg::MODE_HALF) begin
                            ne.mode      = pcb_pkg::MODE_OPEN;
                            ne.open_time = r_now;
                            ne.fail_run  = '0;
                        end else begin
                            ne.fail_run = fr;
                        end
                    end
                    pcb_pkg::REQ_RESET: begin
                        ne.mode     = pcb_pkg::MODE_CLOSED;
                        ne.fail_run = '0;
                        ne.probes   = '0;
                    end
                    pcb_pkg::REQ_TICK: begin
                        n_now = r_now + 32'd1;
                    end
                    default: begin
                    end
                endcase
                we    = found;
                wdata = ne;
                if (create) begin
                    n_valid[ch] = 1'b1;
                    n_tracked   = r_tracked + 7'd1;
                end
                n_res.allowed    = allowed;
                n_res.state      = found ? ne.mode : 2'd0;
                n_res.found      = found;
                n_res.fail_run   = found ? ne.fail_run : '0;
                n_res.probes     = found ? ne.probes : '0;
                n_res.fail_total = found ? ne.fail_total : '0;
                n_res.succ_total = found ? ne.succ_total : '0;
                n_res.opened     = n_opened;
                n_res_vld        = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_valid   <= '0;
            r_tracked <= '0;
            r_now     <= '0;
            r_opened  <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_valid   <= n_valid;
            r_tracked <= n_tracked;
            r_now     <= n_now;
            r_opened  <= n_opened;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    `PCB_AST_NXT(a_ex_gives_res, i_clk, i_rst_n, r_state == S_EX, r_res_vld)
    `PCB_AST_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == S_IDLE)
    `PCB_AST_NOW(a_tracked_max, i_clk, i_rst_n, 1'b1, $countones(r_valid) == 32'(r_tracked))

endmodule

@@ rtl/core/per_channel_circuit_breaker_top.sv @@
// A word goes from the intake queue to the engine, which reads and updates its
// table entry and registers the result; the next word waits for this update.
// A sweep walks all CHANNELS entries, one per cycle, through the table RAM.
// Reset (i_rst_n low, synchronous) clears the table valid bits, counters and
// configuration registers to defaults; the receiver cannot stall o_valid.
// ----------------------------------------------------------------------------
// per_channel_circuit_breaker_top
// Per-channel three-state circuit breaker table with APB configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_channel_circuit_breaker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [5:0]  i_channel_id,
    output logic        o_valid,
    output logic        o_allowed,
    output logic [1:0]  o_breaker_state,
    output logic        o_entry_found,
    output logic [15:0] o_fail_run,
    output logic [7:0]  o_probe_count,
    output logic [31:0] o_fail_total,
    output logic [31:0] o_success_total,
    output logic [31:0] o_opened_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pcb_pkg::t_cfg  r_cfg;
    pcb_pkg::t_item in_item;
    pcb_pkg::t_item q_item;
    pcb_pkg::t_res  res;
    logic           q_vld;
    logic           pop;
    logic [1:0]     ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr  <= 16'd5;
            r_cfg.tmo  <= 31'd30000;
            r_cfg.maxp <= 8'd3;
            r_cfg.maxc <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                pcb_pkg::REG_THR:  r_cfg.thr  <= pwdata[15:0];
                pcb_pkg::REG_TMO:  r_cfg.tmo  <= pwdata[30:0];
                pcb_pkg::REG_MAXP: r_cfg.maxp <= pwdata[7:0];
                pcb_pkg::REG_MAXC: r_cfg.maxc <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            pcb_pkg::REG_THR:  prdata = {16'd0, r_cfg.thr};
            pcb_pkg::REG_TMO:  prdata = {1'b0, r_cfg.tmo};
            pcb_pkg::REG_MAXP: prdata = {24'd0, r_cfg.maxp};
            pcb_pkg::REG_MAXC: prdata = {25'd0, r_cfg.maxc};
            default:           prdata = '0;
        endcase
    end

    assign in_item.req = i_req_type;
    assign in_item.ch  = i_channel_id;

    pcb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (in_item),
        .o_busy  (busy),
        .o_vld   (q_vld),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    pcb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (q_vld),
        .i_item    (q_item),
        .o_pop     (pop),
        .i_cfg     (r_cfg),
        .o_res_vld (o_valid),
        .o_res     (res)
    );

    assign o_allowed       = res.allowed;
    assign o_breaker_state = res.state;
    assign o_entry_found   = res.found;
    assign o_fail_run      = res.fail_run;
    assign o_probe_count   = res.probes;
    assign o_fail_total    = res.fail_total;
    assign o_success_total = res.succ_total;
    assign o_opened_total  = res.opened;

endmodule
